@@ src/cam_pkg.sv @@
`default_nettype none

package cam_pkg;

   // command codes on the request channel
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_BYTE  = 1'b1;

   // result kinds
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      MODE_IMPLIED   = 3'd0,
      MODE_IMMEDIATE = 3'd1,
      MODE_ZERO_PAGE = 3'd2,
      MODE_RELATIVE  = 3'd3,
      MODE_ABSOLUTE  = 3'd4,
      MODE_INDIRECT  = 3'd5,
      MODE_INDEX_X   = 3'd6,
      MODE_INDIRECT_Y = 3'd7
   } mode_type;

   typedef struct packed {
      logic        cmd;
      logic [2:0]  mode;
      logic [15:0] pc_in;
      logic [7:0]  index_offset;
      logic [7:0]  x_reg;
      logic [7:0]  y_reg;
      logic [7:0]  acc;
      logic [7:0]  read_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] address;
      logic [15:0] next_pc;
      logic        page_crossed;
      logic [7:0]  alu_value;
      logic        alu_valid;
   } rsp_type;

   // classified word as it sits in the queue
   typedef struct packed {
      logic    is_start;
      logic    is_quick;
      req_type word;
   } entry_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

`default_nettype wire

@@ src/cpu_addressing_mode_unit.sv @@
// path: a word taken on req is held in the queue until the back end pops it, and its
//   result is captured in the result register, which drives rsp
// throughput: one word per cycle; the back end retires the queue head each cycle that
//   the result register is free or being taken, and a stall on rsp reaches req_ready
//   only once the two-entry queue is full
// reset: synchronous, active high; empties the queue and the result register,
//   closes any open sequence and sets indirect_page_wrap to 1
`default_nettype none

module cpu_addressing_mode_unit
   import cam_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   // result channel
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output rsp_type     rsp_data,
   // register port
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [2:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic     wrap_ff;
   head_type head;
   logic     pop;
   logic     csr_write;

   // register file: one bit at byte offset 0, the next word slot decodes to nothing
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff <= 1'b1;
      end else if (csr_write) begin
         wrap_ff <= pwdata[0];
      end
   end

   // read back: unmapped slot reads zero
   always_comb begin
      prdata = '0;
      if (paddr[2] == 1'b0) begin
         prdata = {31'd0, wrap_ff};
      end
   end

   // front: classify each word and hold it in the queue
   cam_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .head      (head),
      .pop       (pop)
   );

   // back: address sequencer and result register
   cam_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .indirect_page_wrap (wrap_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data           (rsp_data)
   );

endmodule

`default_nettype wire

@@ src/cam_front.sv @@
`default_nettype none

module cam_front
   import cam_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output head_type head,
   input  wire     pop
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   entry_type              classified;
   logic                   push;
   logic                   do_pop;

   // classify: start or byte, and whether the start finishes with no reads
   always_comb begin
      classified.word     = req_data;
      classified.is_start = (req_data.cmd == CMD_START);
      classified.is_quick = (req_data.cmd == CMD_START) &&
                            ((req_data.mode == MODE_IMPLIED) ||
                             (req_data.mode == MODE_IMMEDIATE));
   end

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign do_pop    = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("queue count missed a push");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !head.valid)
      else $error("head valid on empty queue");

endmodule

`default_nettype wire

@@ src/cam_back.sv @@
`default_nettype none

module cam_back
   import cam_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  head_type head,
   output logic     pop,
   input  wire      indirect_page_wrap,
   output logic     rsp_valid,
   input  wire      rsp_ready,
   output rsp_type  rsp_data
);

   logic [2:0]  busy_mode_ff, busy_mode_in;
   logic [2:0]  phase_ff, phase_in;
   logic [15:0] pc_work_ff, pc_work_in;
   logic [7:0]  offset_ff, offset_in;
   logic [7:0]  x_ff, x_in;
   logic [7:0]  y_ff, y_in;
   logic [7:0]  low_ff, low_in;
   logic [15:0] ptr_ff, ptr_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff;

   rsp_type     res;
   logic        res_valid;
   req_type     w;
   logic [7:0]  b;
   logic [2:0]  k;
   logic [15:0] pc_inc;
   logic [15:0] sum;

   assign w      = head.entry.word;
   assign b      = w.read_byte;
   assign k      = phase_ff - 3'd1;
   assign pc_inc = pc_work_ff + 16'd1;
   assign pop    = head.valid && (!out_valid_ff || rsp_ready);

   always_comb begin
      busy_mode_in = busy_mode_ff;
      phase_in     = phase_ff;
      pc_work_in   = pc_work_ff;
      offset_in    = offset_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      low_in       = low_ff;
      ptr_in       = ptr_ff;
      res          = '0;
      res_valid    = 1'b0;
      sum          = '0;

      if (head.entry.is_start) begin
         busy_mode_in = w.mode;
         pc_work_in   = w.pc_in;
         offset_in    = w.index_offset;
         x_in         = w.x_reg;
         y_in         = w.y_reg;
         phase_in     = 3'd0;
         res_valid    = 1'b1;
         if (head.entry.is_quick) begin
            res.kind = KIND_DONE;
            if (w.mode == MODE_IMPLIED) begin
               res.next_pc   = w.pc_in;
               res.alu_value = w.acc;
               res.alu_valid = 1'b1;
            end else begin
               res.address = w.pc_in;
               res.next_pc = w.pc_in + 16'd1;
            end
         end else begin
            res.kind    = KIND_READ;
            res.address = w.pc_in;
            phase_in    = 3'd1;
         end
      end else if (phase_ff != 3'd0) begin
         res_valid = 1'b1;
         res.kind  = KIND_READ;
         phase_in  = phase_ff + 3'd1;
         case (busy_mode_ff)
            MODE_ZERO_PAGE: begin
               pc_work_in  = pc_inc;
               res.kind    = KIND_DONE;
               res.address = {8'h00, 8'(b + offset_ff)};
            end
            MODE_RELATIVE: begin
               pc_work_in  = pc_inc;
               res.kind    = KIND_DONE;
               res.address = {{8{b[7]}}, b};
            end
            MODE_ABSOLUTE: begin
               pc_work_in = pc_inc;
               if (k == 3'd0) begin
                  low_in      = b;
                  res.address = pc_inc;
               end else begin
                  sum              = {b, low_ff} + {8'h00, offset_ff};
                  res.kind         = KIND_DONE;
                  res.address      = sum;
                  res.page_crossed = (sum[15:8] != b);
               end
            end
            MODE_INDIRECT: begin
               if (k == 3'd0) begin
                  pc_work_in  = pc_inc;
                  low_in      = b;
                  res.address = pc_inc;
               end else if (k == 3'd1) begin
                  pc_work_in  = pc_inc;
                  ptr_in      = {b, low_ff};
                  res.address = {b, low_ff};
               end else if (k == 3'd2) begin
                  low_in = b;
                  // high byte fetch stays inside the page when enabled
                  if (indirect_page_wrap && (ptr_ff[7:0] == 8'hFF)) begin
                     res.address = {ptr_ff[15:8], 8'h00};
                  end else begin
                     res.address = ptr_ff + 16'd1;
                  end
               end else begin
                  res.kind    = KIND_DONE;
                  res.address = {b, low_ff};
               end
            end
            MODE_INDEX_X: begin
               if (k == 3'd0) begin
                  pc_work_in  = pc_inc;
                  ptr_in      = {8'h00, 8'(b + x_ff)};
                  res.address = {8'h00, 8'(b + x_ff)};
               end else if (k == 3'd1) begin
                  low_in      = b;
                  res.address = {8'h00, 8'(ptr_ff[7:0] + 8'd1)};
               end else begin
                  res.kind    = KIND_DONE;
                  res.address = {b, low_ff};
               end
            end
            MODE_INDIRECT_Y: begin
               if (k == 3'd0) begin
                  pc_work_in  = pc_inc;
                  ptr_in      = {8'h00, b};
                  res.address = {8'h00, b};
               end else if (k == 3'd1) begin
                  low_in      = b;
                  res.address = {8'h00, 8'(ptr_ff[7:0] + 8'd1)};
               end else begin
                  sum              = {b, low_ff} + {8'h00, y_ff};
                  res.kind         = KIND_DONE;
                  res.address      = sum;
                  res.page_crossed = (sum[15:8] != b);
               end
            end
            default: begin
               res_valid = 1'b0;
               phase_in  = 3'd0;
            end
         endcase
         if (res.kind == KIND_DONE) begin
            phase_in    = 3'd0;
            res.next_pc = pc_work_in;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (!out_valid_ff || rsp_ready) begin
         out_valid_in = pop && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         busy_mode_ff <= busy_mode_in;
         pc_work_ff   <= pc_work_in;
         offset_ff    <= offset_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         low_ff       <= low_in;
         ptr_ff       <= ptr_in;
      end
      if (pop && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= 3'd4)
      else $error("sequencer phase out of range");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.kind == KIND_DONE)) |-> (phase_ff == 3'd0))
      else $error("done word while sequence still open");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.kind == KIND_READ)) |-> (phase_ff != 3'd0))
      else $error("read request with no sequence open");

   a_alu_done: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.alu_valid) |-> (out_ff.kind == KIND_DONE))
      else $error("alu operand on a read request");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import cam_pkg::*;

   // indirect_page_wrap is register 0, so it sits at byte address 0
   localparam logic [2:0]  WRAP_ADDR   = 3'd0;
   localparam int unsigned CYCLE_LIMIT = 500000;
   // cycles to let pass after the last result before touching the register
   localparam int unsigned SETTLE      = 6;

   // tracks the address sequencer word by word and holds the results it owes
   class address_sequence_model;
      bit          page_wrap = 1'b1;
      mode_type    mode      = MODE_IMPLIED;
      logic [2:0]  stage     = '0;   // bytes received plus one, 0 when idle
      logic [15:0] pc_work   = '0;
      logic [7:0]  offset    = '0;
      logic [7:0]  x_idx     = '0;
      logic [7:0]  y_idx     = '0;
      logic [7:0]  lo        = '0;
      logic [15:0] pointer   = '0;
      rsp_type     owed_results[$];
      int unsigned errors    = 0;
      int unsigned checked   = 0;

      function void post_read(logic [15:0] addr);
         rsp_type r;
         r = '0;
         r.kind = KIND_READ;
         r.address = addr;
         stage = stage + 3'd1;
         owed_results.push_back(r);
      endfunction

      function void post_done(logic [15:0] addr, logic crossed);
         rsp_type r;
         r = '0;
         r.kind = KIND_DONE;
         r.address = addr;
         r.next_pc = pc_work;
         r.page_crossed = crossed;
         stage = '0;
         owed_results.push_back(r);
      endfunction

      function void take_word(req_type w);
         rsp_type     r;
         logic [7:0]  b;
         logic [7:0]  t;
         logic [15:0] a;
         logic [2:0]  k;
         b = w.read_byte;
         if (w.cmd == CMD_START) begin
            mode = mode_type'(w.mode);
            pc_work = w.pc_in;
            offset = w.index_offset;
            x_idx = w.x_reg;
            y_idx = w.y_reg;
            stage = '0;
            case (mode)
               MODE_IMPLIED: begin
                  r = '0;
                  r.kind = KIND_DONE;
                  r.next_pc = w.pc_in;
                  r.alu_value = w.acc;
                  r.alu_valid = 1'b1;
                  owed_results.push_back(r);
               end
               MODE_IMMEDIATE: begin
                  pc_work = w.pc_in + 16'd1;
                  post_done(w.pc_in, 1'b0);
               end
               default: post_read(w.pc_in);
            endcase
         end else if (stage != 3'd0) begin
            k = stage - 3'd1;
            case (mode)
               MODE_ZERO_PAGE: begin
                  pc_work = pc_work + 16'd1;
                  t = b + offset;
                  post_done({8'h00, t}, 1'b0);
               end
               MODE_RELATIVE: begin
                  pc_work = pc_work + 16'd1;
                  post_done({{8{b[7]}}, b}, 1'b0);
               end
               MODE_ABSOLUTE: begin
                  pc_work = pc_work + 16'd1;
                  if (k == 3'd0) begin
                     lo = b;
                     post_read(pc_work);
                  end else begin
                     a = {b, lo} + {8'h00, offset};
                     post_done(a, a[15:8] != b);
                  end
               end
               MODE_INDIRECT: begin
                  if (k == 3'd0) begin
                     pc_work = pc_work + 16'd1;
                     lo = b;
                     post_read(pc_work);
                  end else if (k == 3'd1) begin
                     pc_work = pc_work + 16'd1;
                     pointer = {b, lo};
                     post_read(pointer);
                  end else if (k == 3'd2) begin
                     lo = b;
                     // high byte from the start of the same page when wrapping
                     if (page_wrap && pointer[7:0] == 8'hFF)
                        a = {pointer[15:8], 8'h00};
                     else
                        a = pointer + 16'd1;
                     post_read(a);
                  end else begin
                     post_done({b, lo}, 1'b0);
                  end
               end
               MODE_INDEX_X: begin
                  if (k == 3'd0) begin
                     pc_work = pc_work + 16'd1;
                     t = b + x_idx;
                     pointer = {8'h00, t};
                     post_read(pointer);
                  end else if (k == 3'd1) begin
                     lo = b;
                     t = pointer[7:0] + 8'd1;
                     post_read({8'h00, t});
                  end else begin
                     post_done({b, lo}, 1'b0);
                  end
               end
               MODE_INDIRECT_Y: begin
                  if (k == 3'd0) begin
                     pc_work = pc_work + 16'd1;
                     pointer = {8'h00, b};
                     post_read(pointer);
                  end else if (k == 3'd1) begin
                     lo = b;
                     t = pointer[7:0] + 8'd1;
                     post_read({8'h00, t});
                  end else begin
                     a = {b, lo} + {8'h00, y_idx};
                     post_done(a, a[15:8] != b);
                  end
               end
               default: stage = '0;
            endcase
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (owed_results.size() == 0) begin
            errors++;
            if (errors <= 30)
               $display("%0t: expected nothing, got %p", $time, got);
            return;
         end
         want = owed_results.pop_front();
         checked++;
         if (got !== want) begin
            errors++;
            if (errors <= 30)
               $display("%0t: expected %p, got %p", $time, want, got);
         end
      endfunction

      function int unsigned owed();
         return owed_results.size();
      endfunction
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   req_type     req_data  = '0;
   logic        rsp_ready = 1'b1;
   logic        psel      = 1'b0;
   logic        penable   = 1'b0;
   logic        pwrite    = 1'b0;
   logic [2:0]  paddr     = '0;
   logic [31:0] pwdata    = '0;
   logic        req_ready;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic [31:0] prdata;
   logic        pready;

   address_sequence_model book;
   bit          quiet       = 1'b1;   // no idling on either side while set
   int unsigned words       = 0;
   int unsigned cycles      = 0;
   int unsigned ready_hold  = 0;
   int unsigned ready_roll  = 0;

   cpu_addressing_mode_unit i_dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data,
      .psel,
      .penable,
      .pwrite,
      .paddr,
      .pwdata,
      .prdata,
      .pready
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("** cpu_addressing_mode_unit: FAILED **");
         $finish;
      end
   end

   // every result word taken is held against the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_result(rsp_data);
   end

   // receiver back-pressure: mostly short stalls, now and then a long one
   always @(negedge clock) begin
      if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold != 0) begin
         ready_hold--;
         rsp_ready <= 1'b0;
      end else begin
         ready_roll = $urandom_range(99);
         if (ready_roll < 3) begin
            ready_hold = $urandom_range(40, 10);
            rsp_ready <= 1'b0;
         end else if (ready_roll < 20) begin
            ready_hold = $urandom_range(2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // byte values lean on the edges: zero, all ones, and either side of the sign bit
   function automatic logic [7:0] rand_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic req_type start_word(mode_type m, logic [15:0] pc, logic [7:0] off,
                                          logic [7:0] xv, logic [7:0] yv, logic [7:0] av);
      req_type w;
      w = '0;
      w.cmd = CMD_START;
      w.mode = m;
      w.pc_in = pc;
      w.index_offset = off;
      w.x_reg = xv;
      w.y_reg = yv;
      w.acc = av;
      w.read_byte = rand_byte();   // no meaning on a start
      return w;
   endfunction

   // data word; the other fields carry noise the block has to ignore
   function automatic req_type byte_word(logic [7:0] b);
      req_type w;
      w.cmd = CMD_BYTE;
      w.mode = 3'($urandom_range(7));
      w.pc_in = 16'($urandom_range(65535));
      w.index_offset = rand_byte();
      w.x_reg = rand_byte();
      w.y_reg = rand_byte();
      w.acc = rand_byte();
      w.read_byte = b;
      return w;
   endfunction

   // entered and left at a falling edge; valid stays up across back-to-back words
   task automatic send(input req_type w);
      int unsigned gap;
      int unsigned roll;
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      book.take_word(w);
      words++;
      @(negedge clock);
      gap = 0;
      if (!quiet) begin
         roll = $urandom_range(99);
         if (roll < 4)
            gap = $urandom_range(40, 10);
         else if (roll < 25)
            gap = $urandom_range(3, 1);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // hold off until every owed result is in, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      while (book.owed() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(input logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= WRAP_ADDR;
      pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      book.page_wrap = v[0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_check(input logic [31:0] want);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= WRAP_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         book.errors++;
         $display("%0t: indirect_page_wrap expected %h, got %h", $time, want, prdata);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // mostly complete sequences with random content; some cut short, some with
   // a stray data word behind them that the block has to drop
   task automatic random_run(input int unsigned target);
      int unsigned counted;
      int unsigned n;
      int unsigned roll;
      int unsigned i;
      mode_type    m;
      logic [15:0] pc;
      counted = 0;
      while (counted < target) begin
         roll = $urandom_range(99);
         if (roll < 4) begin
            send(byte_word(rand_byte()));
         end else begin
            m = mode_type'($urandom_range(7));
            pc = 16'($urandom_range(65535));
            if ($urandom_range(9) == 0)
               pc[15:2] = '1;   // near the top so the pc wraps
            send(start_word(m, pc, rand_byte(), rand_byte(), rand_byte(), rand_byte()));
            case (m)
               MODE_IMPLIED, MODE_IMMEDIATE: n = 0;
               MODE_ZERO_PAGE, MODE_RELATIVE: n = 1;
               MODE_ABSOLUTE:                 n = 2;
               MODE_INDIRECT:                 n = 4;
               default:                       n = 3;
            endcase
            // cut short: the next start abandons this sequence
            if (n != 0 && roll >= 92)
               n = $urandom_range(n - 1);
            for (i = 0; i < n; i++)
               send(byte_word(rand_byte()));
            counted += n + 1;
            if (roll >= 88 && roll < 92)
               send(byte_word(rand_byte()));
         end
      end
   endtask

   initial begin
      book = new;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // page wrap comes out of reset on
      csr_check(32'd1);

      // directed pass, no idling on either side
      quiet = 1'b1;
      send(start_word(MODE_IMPLIED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send(start_word(MODE_IMMEDIATE, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00));
      // data word with nothing pending is dropped
      send(byte_word(8'hA5));
      // zero page sum wraps inside page zero
      send(start_word(MODE_ZERO_PAGE, 16'h1234, 8'hFF, 8'h00, 8'h00, 8'h00));
      send(byte_word(8'hFF));
      // relative offsets on either side of the sign bit
      send(start_word(MODE_RELATIVE, 16'h8000, 8'h00, 8'h00, 8'h00, 8'h00));
      send(byte_word(8'h80));
      send(start_word(MODE_RELATIVE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
      send(byte_word(8'h7F));
      // absolute indexed across a page and past the top of memory, pc wraps too
      send(start_word(MODE_ABSOLUTE, 16'hFFFF, 8'hFF, 8'h00, 8'h00, 8'h00));
      send(byte_word(8'hFF));
      send(byte_word(8'hFF));
      // indirect through a pointer ending in ff, wrap on
      send(start_word(MODE_INDIRECT, 16'h0200, 8'h00, 8'h00, 8'h00, 8'h00));
      send(byte_word(8'hFF));
      send(byte_word(8'h12));
      send(byte_word(8'h34));
      send(byte_word(8'h56));
      // (zp,X) where the pointer lands on ff and its high byte wraps to 00
      send(start_word(MODE_INDEX_X, 16'h0300, 8'h00, 8'hFF, 8'h00, 8'h00));
      send(byte_word(8'h00));
      send(byte_word(8'hCD));
      send(byte_word(8'hAB));
      // (zp),Y with a page cross
      send(start_word(MODE_INDIRECT_Y, 16'h0400, 8'h00, 8'h00, 8'hFF, 8'h00));
      send(byte_word(8'hFF));
      send(byte_word(8'h80));
      send(byte_word(8'h12));
      // new start abandons an absolute fetch halfway through
      send(start_word(MODE_ABSOLUTE, 16'h4000, 8'h10, 8'h00, 8'h00, 8'h00));
      send(byte_word(8'h10));
      send(start_word(MODE_ZERO_PAGE, 16'h0000, 8'h01, 8'h00, 8'h00, 8'h00));
      send(byte_word(8'hFF));
      drain();

      // wrap off: the same pointer now steps into the next page
      csr_write(32'd0);
      csr_check(32'd0);
      send(start_word(MODE_INDIRECT, 16'hFFFE, 8'h00, 8'h00, 8'h00, 8'h00));
      send(byte_word(8'hFF));
      send(byte_word(8'h12));
      send(byte_word(8'h34));
      send(byte_word(8'h56));
      quiet = 1'b0;
      random_run(500);
      drain();

      csr_write(32'd1);
      csr_check(32'd1);
      random_run(500);
      drain();

      // last stretch starts at full rate, then goes back to random stalls
      csr_write(32'd0);
      csr_check(32'd0);
      quiet = 1'b1;
      random_run(250);
      quiet = 1'b0;
      random_run(250);
      drain();

      $display("%0d words driven and %0d results checked over all eight modes,",
               words, book.checked);
      $display("with indirect page wrap both on and off and random stalls on both sides");
      if (book.errors == 0)
         $display("** cpu_addressing_mode_unit: PASSED **");
      else
         $display("** cpu_addressing_mode_unit: FAILED **");
      $finish;
   end

endmodule
